>>> rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 9;
    localparam int SUM_W   = 17;
    localparam int GAP_W   = 16;

    localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 16'd300;
    localparam logic [GAP_W-1:0] GAP_TICKS_MAX   = 16'hFFFF;
    localparam logic [BYTE_W-1:0] LENGTH_MAX     = 8'd255;

    // Kind of an input transaction.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_last;
        logic               checksum_ok;
        logic               partial_dropped;
    } sfr_result_t;

endpackage

>>> rtl/sfr_deframe.sv
// Frame state, gap timer and checksum evaluation for the serial frame receiver.
module sfr_deframe
    import sfr_pkg::*;
#(
    parameter int LENGTH_POS  = 5,
    parameter int FIXED_BYTES = 8,
    parameter int CHECK_BYTES = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               req_type,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic [GAP_W-1:0]   gap_limit,
    output logic               res_valid,
    output sfr_result_t        res
);

    localparam int CHK_W = 8 * CHECK_BYTES;
    localparam logic [INDEX_W-1:0] COUNT_MAX =
        INDEX_W'(FIXED_BYTES + 255 + CHECK_BYTES);

    logic [INDEX_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]  payload_length_reg, payload_length_next;
    logic [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [CHK_W-1:0]   check_value_reg, check_value_next;
    logic [GAP_W-1:0]   gap_ticks_reg, gap_ticks_next;

    logic               timeout;
    logic [INDEX_W-1:0] base_count;
    logic [BYTE_W-1:0]  base_len;
    logic [SUM_W-1:0]   base_sum;
    logic [CHK_W-1:0]   base_check;
    logic [INDEX_W-1:0] count;
    logic [INDEX_W-1:0] total;
    logic [SUM_W-1:0]   sum_new;
    logic [CHK_W-1:0]   check_new;
    logic [CHK_W+7:0]   check_shift;
    logic [SUM_W-1:0]   window;
    logic [SUM_W-1:0]   data_sum;
    logic               is_last;
    logic               sum_fits;

    always_comb
    begin
        // A gap longer than the limit throws away whatever was collected.
        timeout    = gap_ticks_reg > gap_limit;
        base_count = timeout ? '0 : byte_count_reg;
        base_len   = timeout ? '0 : payload_length_reg;
        base_sum   = timeout ? '0 : running_sum_reg;
        base_check = timeout ? '0 : check_value_reg;

        count       = base_count + INDEX_W'(1);
        sum_new     = base_sum + SUM_W'(rx_byte);
        check_shift = {rx_byte, base_check};
        check_new   = check_shift[CHK_W+7:8];

        window = '0;
        for (int i = 0; i < CHECK_BYTES; i++)
        begin
            window = window + SUM_W'(check_new[i*8 +: 8]);
        end
        data_sum = sum_new - window;
        sum_fits = (data_sum >> CHK_W) == '0;

        total = INDEX_W'(FIXED_BYTES) + INDEX_W'(base_len) + INDEX_W'(CHECK_BYTES);
        is_last = (count != INDEX_W'(LENGTH_POS)) && (count >= total);

        res_valid           = step && (req_type == REQ_BYTE);
        res.frame_byte      = rx_byte;
        res.byte_index      = base_count;
        res.frame_last      = is_last;
        res.checksum_ok     = is_last && sum_fits && (~data_sum[CHK_W-1:0] == check_new);
        res.partial_dropped = timeout && (byte_count_reg != '0);

        byte_count_next     = byte_count_reg;
        payload_length_next = payload_length_reg;
        running_sum_next    = running_sum_reg;
        check_value_next    = check_value_reg;
        gap_ticks_next      = gap_ticks_reg;

        if (step)
        begin
            if (req_type == REQ_TICK)
            begin
                if (gap_ticks_reg != GAP_TICKS_MAX)
                begin
                    gap_ticks_next = gap_ticks_reg + GAP_W'(1);
                end
            end
            else
            begin
                gap_ticks_next = '0;
                if (is_last)
                begin
                    byte_count_next     = '0;
                    payload_length_next = '0;
                    running_sum_next    = '0;
                    check_value_next    = '0;
                end
                else
                begin
                    byte_count_next     = count;
                    payload_length_next = (count == INDEX_W'(LENGTH_POS)) ? rx_byte : base_len;
                    running_sum_next    = sum_new;
                    check_value_next    = check_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            payload_length_reg <= '0;
            running_sum_reg    <= '0;
            check_value_reg    <= '0;
            gap_ticks_reg      <= '0;
        end
        else
        begin
            byte_count_reg     <= byte_count_next;
            payload_length_reg <= payload_length_next;
            running_sum_reg    <= running_sum_next;
            check_value_reg    <= check_value_next;
            gap_ticks_reg      <= gap_ticks_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_MAX)
        else $error("byte count beyond the longest frame");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_last |=> byte_count_reg == '0 && running_sum_reg == '0)
        else $error("frame state not cleared after the closing byte");

    a_ok_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.checksum_ok |-> res.frame_last)
        else $error("checksum verdict outside the closing byte");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && req_type == REQ_TICK && gap_ticks_reg != GAP_TICKS_MAX
        |=> gap_ticks_reg == $past(gap_ticks_reg) + GAP_W'(1))
        else $error("tick not counted");

endmodule

>>> rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver: stream ports, configuration and result register.
//
// The serial frame receiver takes one transaction per clock cycle on its slave
// stream: either a received byte or a single time tick. Every accepted byte comes
// out in the next cycle on the master stream, echoed together with its position in the
// current frame; ticks produce nothing on the output. A frame is length-prefixed:
// the byte at position LENGTH_POS-1 carries the payload length, and the frame
// closes after FIXED_BYTES plus that length plus CHECK_BYTES bytes, with tlast
// marking the closing byte. The check field is the last CHECK_BYTES bytes, read
// little-endian, and the frame passes when the sum of all earlier bytes fits in
// the check width and its complement equals the check field. When more ticks
// than the configured gap limit arrive between two bytes, the partial frame is
// discarded and the next byte starts a new frame with partial_dropped set. The
// block sustains one transaction per cycle: all frame and checksum logic sits
// between the slave port and a single output register, and s_tready only drops
// when that register holds a result that the sink has not taken. The gap limit
// resets to 300 and is written through the cfg channel, which is always ready;
// write it only while the block is idle.
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int LENGTH_POS  = 5,
    parameter int FIXED_BYTES = 8,
    parameter int CHECK_BYTES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type
    // Master stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_byte, [16:8] byte_index, [23:17] zero
    output logic [1:0]  m_tuser,   // [0] checksum_ok, [1] partial_dropped
    output logic        m_tlast,   // frame_last
    // Configuration write channel: gap limit in ticks.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [GAP_W-1:0] gap_limit_reg;
    logic             m_tvalid_reg;
    sfr_result_t      result_reg;
    logic             step;
    logic             res_valid;
    sfr_result_t      res;

    // The output register frees up in the same cycle that the sink takes it.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= GAP_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gap_limit_reg <= cfg_data;
        end
    end

    sfr_deframe #(
        .LENGTH_POS  (LENGTH_POS),
        .FIXED_BYTES (FIXED_BYTES),
        .CHECK_BYTES (CHECK_BYTES)
    ) u_deframe (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .req_type  (s_tuser),
        .rx_byte   (s_tdata),
        .gap_limit (gap_limit_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // A tick transaction leaves the output register empty once it has been read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, result_reg.byte_index, result_reg.frame_byte};
    assign m_tuser  = {result_reg.partial_dropped, result_reg.checksum_ok};
    assign m_tlast  = result_reg.frame_last;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid_reg && !m_tready)
        else $error("input stalled with room in the output register");

    a_byte_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && s_tuser == REQ_BYTE |=> m_tvalid_reg && m_tdata[7:0] == $past(s_tdata))
        else $error("accepted byte did not reach the output register");

endmodule

>>> tb/serial_frame_receiver_tb.sv
// Self-checking testbench for the serial frame receiver: stream driver, monitor and frame predictor.
module serial_frame_receiver_tb
    import sfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LENGTH_POS  = 5;
    localparam int FIXED_BYTES = 8;
    localparam int CHECK_BYTES = 2;

    // One slave-side transaction: a received byte or a single tick.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] value;
    } rx_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    serial_frame_receiver #(
        .LENGTH_POS  (LENGTH_POS),
        .FIXED_BYTES (FIXED_BYTES),
        .CHECK_BYTES (CHECK_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Items waiting to be driven, and echoes the block still owes us.
    rx_item_t    pending_q[$];
    sfr_result_t echo_q[$];

    int in_queued   = 0;
    int in_accepted = 0;
    int stim_bytes  = 0;
    int errors      = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit in_fire     = 1'b0;
    bit cfg_seen    = 1'b0;
    logic [15:0] cur_gap = GAP_LIMIT_RESET;

    // Private copy of the deframer state, updated on every accepted transaction.
    logic [INDEX_W-1:0] rx_count;
    logic [BYTE_W-1:0]  rx_len;
    logic [SUM_W-1:0]   rx_sum;
    logic [15:0]        rx_window;
    logic [GAP_W-1:0]   idle_ticks;
    logic [GAP_W-1:0]   gap_limit_q;

    sfr_result_t want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A tick only advances the idle counter, which saturates at its maximum.
    function automatic void count_tick();
        if (idle_ticks != GAP_TICKS_MAX)
            idle_ticks = idle_ticks + 1'b1;
    endfunction

    // Works out the echo for one received byte and advances the frame state.
    function automatic sfr_result_t predict_byte(input logic [BYTE_W-1:0] b);
        sfr_result_t      r;
        int               cnt;
        int               total;
        logic [SUM_W-1:0] data_sum;
        r = '0;
        // A gap longer than the limit discards whatever was collected so far.
        if (idle_ticks > gap_limit_q)
        begin
            r.partial_dropped = (rx_count != 0);
            rx_count  = '0;
            rx_len    = '0;
            rx_sum    = '0;
            rx_window = '0;
        end
        idle_ticks   = '0;
        r.frame_byte = b;
        r.byte_index = rx_count;
        cnt       = int'(rx_count) + 1;
        rx_sum    = rx_sum + SUM_W'(b);
        rx_window = {b, rx_window[15:8]};
        if (cnt == LENGTH_POS)
        begin
            // The length byte itself is never tested for completion.
            rx_len   = b;
            rx_count = INDEX_W'(cnt);
        end
        else
        begin
            total = FIXED_BYTES + int'(rx_len) + CHECK_BYTES;
            if (cnt >= total)
            begin
                data_sum = rx_sum - SUM_W'(rx_window[7:0]) - SUM_W'(rx_window[15:8]);
                r.frame_last  = 1'b1;
                r.checksum_ok = (data_sum <= SUM_W'(16'hFFFF)) && (~data_sum[15:0] == rx_window);
                rx_count  = '0;
                rx_len    = '0;
                rx_sum    = '0;
                rx_window = '0;
            end
            else
            begin
                rx_count = INDEX_W'(cnt);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Monitor: everything is sampled at the rising edge, where inputs have been
    // stable since the previous falling edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire = 1'b0;
            rx_count    = '0;
            rx_len      = '0;
            rx_sum      = '0;
            rx_window   = '0;
            idle_ticks  = '0;
            gap_limit_q = GAP_LIMIT_RESET;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (echo_q.size() == 0)
                begin
                    $display("%0t: unexpected echo: expected none, got data %h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    want = echo_q.pop_front();
                    check_field("frame_byte", want.frame_byte, m_tdata[7:0]);
                    check_field("byte_index", want.byte_index, m_tdata[16:8]);
                    check_field("frame_last", want.frame_last, m_tlast);
                    check_field("checksum_ok", want.checksum_ok, m_tuser[0]);
                    check_field("partial_dropped", want.partial_dropped, m_tuser[1]);
                end
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                in_accepted++;
                if (s_tuser == REQ_TICK)
                    count_tick();
                else
                    echo_q.insert(echo_q.size(), predict_byte(s_tdata));
            end
            if (cfg_valid && cfg_ready)
            begin
                gap_limit_q = cfg_data;
                cfg_seen    = 1'b1;
            end
        end
    end

    // Driver: a new transaction is offered at the falling edge once the previous
    // one has been taken; the sink stalls at random at the same edge.
    always @(negedge clk)
    begin : drive_blk
        logic     nv;
        logic [7:0] nd;
        logic     nu;
        rx_item_t it;
        nv = s_tvalid;
        nd = s_tdata;
        nu = s_tuser;
        if (!rst_n)
        begin
            nv = 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            nv = 1'b0;
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_q.pop_front();
                nv = 1'b1;
                nd = it.value;
                nu = it.kind;
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
        s_tuser  <= nu;
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    task automatic push_byte(input logic [7:0] b);
        pending_q.insert(pending_q.size(), rx_item_t'{kind: REQ_BYTE, value: b});
        in_queued++;
        stim_bytes++;
    endtask

    // Ticks carry random filler in tdata so that the byte lane is exercised too.
    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            pending_q.insert(pending_q.size(), rx_item_t'{kind: REQ_TICK, value: 8'($urandom)});
            in_queued++;
        end
    endtask

    // A gap just past the limit, which drops any partial frame and realigns.
    task automatic push_timeout();
        if (cur_gap != GAP_TICKS_MAX)
            push_ticks(int'(cur_gap) + 1 + $urandom_range(2));
    endtask

    // Builds one frame, with a bad checksum when corrupt is set. fill selects the byte content:
    // 0 random, 1 all ones, 2 all zeros. Short gaps no longer than the limit may fall between bytes.
    task automatic push_frame(input int len, input bit corrupt, input int fill,
                              input int gap_pct);
        logic [7:0]  b;
        logic [16:0] sum;
        logic [15:0] chk;
        int          n;
        sum = '0;
        n   = FIXED_BYTES + len + CHECK_BYTES;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0 && cur_gap != 0 && $urandom_range(99) < gap_pct)
                push_ticks($urandom_range(1, (cur_gap < 4) ? int'(cur_gap) : 4));
            if (i == FIXED_BYTES + len)
            begin
                chk = ~sum[15:0];
                if (corrupt)
                    chk = chk ^ 16'($urandom_range(1, 16'hFFFF));
            end
            if (i == LENGTH_POS - 1)
                b = 8'(len);
            else if (i >= FIXED_BYTES + len)
                b = (i == FIXED_BYTES + len) ? chk[7:0] : chk[15:8];
            else if (fill == 1)
                b = 8'hFF;
            else if (fill == 2)
                b = 8'h00;
            else
                b = 8'($urandom);
            if (i < FIXED_BYTES + len)
                sum = sum + 17'(b);
            push_byte(b);
        end
    endtask

    task automatic write_gap_limit(input logic [15:0] v);
        @(negedge clk);
        cfg_seen  = 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        cur_gap   = v;
        do @(negedge clk); while (!cfg_seen);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued transaction is taken and every echo has come,
    // then lets a trailing tick settle.
    task automatic wait_idle();
        while (in_accepted != in_queued || echo_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int gap_set[4];
        int send_set[4];
        int stall_set[4];
        int r;
        int len;
        gap_set   = '{0, 7, 12, 2};
        send_set  = '{0, 78, 0, 19};
        stall_set = '{0, 0, 78, 19};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_BYTE;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling: frames of all zeros and all ones, and a bad
        // checksum.
        write_gap_limit(GAP_LIMIT_RESET);
        push_frame(0, 1'b0, 2, 0);
        push_frame(0, 1'b0, 1, 0);
        push_frame(1, 1'b1, 0, 0);
        wait_idle();

        // The gap boundary, checked at a short limit.
        write_gap_limit(16'd4);
        // Timeout while no frame is open: nothing to drop.
        push_ticks(int'(cur_gap) + 1);
        push_byte(8'hA5);
        push_byte(8'h5A);
        // Exactly at the limit the frame survives; one tick more drops it.
        push_ticks(int'(cur_gap));
        push_byte(8'h3C);
        push_ticks(int'(cur_gap) + 1);
        push_byte(8'hC3);
        // Hold the sender until the block has caught up.
        wait_idle();

        // With the largest limit a gap does not time out.
        write_gap_limit(GAP_TICKS_MAX);
        push_byte(8'h01);
        push_ticks(12);
        push_byte(8'h80);
        wait_idle();

        // Limit zero: a single tick is already too long.
        write_gap_limit(16'd0);
        push_ticks(1);
        push_byte(8'h7E);
        push_ticks(1);
        // Longest frame of all ones: the data sum overflows the check width.
        push_frame(int'(LENGTH_MAX), 1'b0, 1, 0);
        wait_idle();

        // Random part: mostly well-formed frames with random content, the rest
        // truncated frames and raw noise, over several idling patterns.
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            send_idle_pct = send_set[p];
            stall_pct     = stall_set[p];
            if (gap_set[p] != int'(cur_gap))
                write_gap_limit(16'(gap_set[p]));
            stim_bytes = 0;
            while (stim_bytes < 30)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6);
                    push_frame(len, $urandom_range(4) == 0, 0, 25);
                end
                else if (r < 85)
                begin
                    for (int i = $urandom_range(1, 8); i > 0; i--)
                        push_byte(8'($urandom));
                    push_timeout();
                end
                else
                begin
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                    begin
                        if ($urandom_range(1) == 0)
                            push_byte(8'($urandom));
                        else
                            push_ticks(1);
                    end
                    push_timeout();
                end
            end
        end
        wait_idle();
        repeat (10) @(negedge clk);

        if (errors == 0)
            $display("serial_frame_receiver_tb: clean");
        else
            $display("serial_frame_receiver_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("serial_frame_receiver_tb: errors");
        $finish;
    end

endmodule
